>>> design/ddd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_pkg: shared types, constants and calendar functions
// Field widths, year limit, constant division by 100 and month tables
// used by the date difference unit.
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DN_W    = 23;
    localparam int DIST_W  = 23;

    localparam logic [16:0] MAX_YEAR = 17'd9999;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DN_W-1:0] DAYS_PER_YEAR = 23'd365;

    localparam logic signed [DIST_W:0] DIST_MAX = 24'sd4194303;
    localparam logic signed [DIST_W:0] DIST_MIN = -24'sd4194304;

    // x / 100 as x * 5243 >> 19, exact for x below 43690
    localparam logic [32:0] DIV100_MUL   = 33'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } ddd_date_t;

    typedef struct packed {
        logic            ok;
        logic [DN_W-1:0] day_num;
    } ddd_conv_t;

    function automatic logic [YEAR_W-1:0] div100(input logic [YEAR_W-1:0] x);
        logic [32:0] prod;
        prod = 33'(x) * DIV100_MUL;
        return YEAR_W'(prod >> DIV100_SHIFT);
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MONTH_FEB)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
        begin
            len = 5'd30;
        end
        return len;
    endfunction

    // days before the month in a year that starts in March
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

>>> design/ddd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_if: date pair and result channels
// Valid/ready channels carrying two calendar dates in and one signed
// day distance with an error flag out.
// ----------------------------------------------------------------------------
interface ddd_dates_if;
    logic                         valid;
    logic                         ready;
    logic [ddd_pkg::DAY_W-1:0]    first_day;
    logic [ddd_pkg::MONTH_W-1:0]  first_month;
    logic [ddd_pkg::YEAR_W-1:0]   first_year;
    logic [ddd_pkg::DAY_W-1:0]    second_day;
    logic [ddd_pkg::MONTH_W-1:0]  second_month;
    logic [ddd_pkg::YEAR_W-1:0]   second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );
    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );
endinterface

interface ddd_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [ddd_pkg::DIST_W-1:0] day_distance;
    logic                             bad_date;

    modport source (
        output valid, day_distance, bad_date,
        input  ready
    );
    modport sink (
        input  valid, day_distance, bad_date,
        output ready
    );
endinterface

>>> design/date_difference_days_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_difference_days_unit: signed day count between two dates
// Accepts a pair of Gregorian dates and returns second minus first in
// days, with a flag for an impossible date.
// ----------------------------------------------------------------------------
// Takes one date pair per cycle while dates.ready is high and returns
// its result through the input register, where both dates are checked and
// turned into day numbers, then through the result register after the
// subtraction. The throughput is one beat per clock; dates.ready falls
// only while the result register holds a beat that result.ready refuses
// and the input register is full. bad_date forces day_distance to zero.
module date_difference_days_unit (
    input  logic               clk,
    input  logic               rst_n,
    ddd_dates_if.sink          dates,
    ddd_result_if.source       result
);

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    ddd_pkg::ddd_date_t                  s1_first_reg;
    ddd_pkg::ddd_date_t                  s1_second_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [ddd_pkg::DIST_W-1:0]   out_dist_reg;
    logic signed [ddd_pkg::DIST_W-1:0]   out_dist_next;
    logic                                out_bad_reg;
    logic                                out_bad_next;

    logic                                advance;
    logic                                take;
    ddd_pkg::ddd_conv_t                  conv_first;
    ddd_pkg::ddd_conv_t                  conv_second;
    logic signed [ddd_pkg::DIST_W:0]     diff;

    ddd_day_number u_first (
        .date (s1_first_reg),
        .conv (conv_first)
    );

    ddd_day_number u_second (
        .date (s1_second_reg),
        .conv (conv_second)
    );

    assign advance      = !out_valid_reg || result.ready;
    assign dates.ready  = !s1_valid_reg || advance;
    assign take         = dates.valid && dates.ready;

    always_comb
    begin
        s1_valid_next  = dates.ready ? dates.valid : s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;

        diff = $signed({1'b0, conv_second.day_num}) - $signed({1'b0, conv_first.day_num});

        out_bad_next = !(conv_first.ok && conv_second.ok);
        if (out_bad_next)
        begin
            out_dist_next = '0;
        end
        else if (diff > ddd_pkg::DIST_MAX)
        begin
            out_dist_next = ddd_pkg::DIST_MAX[ddd_pkg::DIST_W-1:0];
        end
        else if (diff < ddd_pkg::DIST_MIN)
        begin
            out_dist_next = ddd_pkg::DIST_MIN[ddd_pkg::DIST_W-1:0];
        end
        else
        begin
            out_dist_next = diff[ddd_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the input beat until it moves on
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_first_reg  <= '{day: dates.first_day, month: dates.first_month,
                               year: dates.first_year};
            s1_second_reg <= '{day: dates.second_day, month: dates.second_month,
                               year: dates.second_year};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_dist_reg <= out_dist_next;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.day_distance = out_dist_reg;
    assign result.bad_date     = out_bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bad_reg |-> out_dist_reg == '0)
        else $error("bad date with nonzero distance");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> dates.ready)
        else $error("input stalled with empty result register");

    a_advance_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("beat lost between stages");

    a_same_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && (s1_first_reg == s1_second_reg)
        |=> out_dist_reg == '0)
        else $error("equal dates give nonzero distance");

endmodule

>>> design/ddd_day_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_day_number: date check and day number
// Checks one date against the Gregorian calendar and converts it to a
// day count from a March-based epoch in closed form.
// ----------------------------------------------------------------------------
module ddd_day_number (
    input  ddd_pkg::ddd_date_t date,
    output ddd_pkg::ddd_conv_t conv
);

    logic [ddd_pkg::YEAR_W-1:0]  q100_y;
    logic [ddd_pkg::YEAR_W-1:0]  r100_y;
    logic                        leap;
    logic [ddd_pkg::DAY_W-1:0]   mlen;
    logic                        year_ok;
    logic                        month_ok;
    logic                        day_ok;
    logic [ddd_pkg::YEAR_W-1:0]  ya;
    logic [ddd_pkg::MONTH_W-1:0] mp;
    logic [ddd_pkg::YEAR_W-1:0]  q4;
    logic [ddd_pkg::YEAR_W-1:0]  q100;
    logic [ddd_pkg::YEAR_W-1:0]  q400;

    always_comb
    begin
        q100_y = ddd_pkg::div100(date.year);
        r100_y = date.year - ddd_pkg::YEAR_W'(q100_y * 14'd100);
        leap   = (date.year[1:0] == 2'd0) && ((r100_y != '0) || (q100_y[1:0] == 2'd0));
        mlen   = ddd_pkg::month_length(date.month, leap);

        year_ok  = (date.year != '0) && (17'(date.year) <= ddd_pkg::MAX_YEAR);
        month_ok = (date.month >= ddd_pkg::MONTH_JAN) && (date.month <= ddd_pkg::MONTH_DEC);
        day_ok   = (date.day != '0) && (date.day <= mlen);

        if (date.month < ddd_pkg::MONTH_MAR)
        begin
            ya = date.year - 14'd1;
            mp = date.month + 4'd9;
        end
        else
        begin
            ya = date.year;
            mp = date.month - ddd_pkg::MONTH_MAR;
        end

        q4   = ya >> 2;
        q100 = ddd_pkg::div100(ya);
        q400 = ddd_pkg::div100(q4);

        conv.ok      = year_ok && month_ok && day_ok;
        conv.day_num = ddd_pkg::DN_W'(ya) * ddd_pkg::DAYS_PER_YEAR
                     + ddd_pkg::DN_W'(q4) - ddd_pkg::DN_W'(q100) + ddd_pkg::DN_W'(q400)
                     + ddd_pkg::DN_W'(ddd_pkg::month_offset(mp))
                     + ddd_pkg::DN_W'(date.day);
    end

endmodule
